FILE: rtl/mkdr_pkg.sv
// Shared types and constants of the matrix key debounce and repeat block.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package mkdr_pkg;

    localparam int RESULT_CAP = 20;
    localparam int MAP_BITS   = 20;
    localparam int TBL_DIM    = 8;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SCAN_INTERVAL   = 3'd0;
    localparam logic [2:0] CFG_DEBOUNCE_TIME   = 3'd1;
    localparam logic [2:0] CFG_LONG_PRESS_TIME = 3'd2;
    localparam logic [2:0] CFG_REPEAT_INTERVAL = 3'd3;
    localparam logic [2:0] CFG_MAX_EVENTS      = 3'd4;

    // Event kinds.
    localparam logic [1:0] EV_PRESS   = 2'd0;
    localparam logic [1:0] EV_LONG    = 2'd1;
    localparam logic [1:0] EV_REPEAT  = 2'd2;
    localparam logic [1:0] EV_RELEASE = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_PRESSED  = 2'd2,
        PH_LONG     = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_EVAL,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [19:0] pressed_map;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] key_id;
        logic [1:0] event_kind;
        logic       last_event;
    } t_out_beat;

    // Controller to datapath.
    typedef struct packed {
        logic load;   // capture the incoming sample
        logic start;  // sample accepted: stamp time, rewind the key walk
        logic rd;     // read the state of the current key
        logic eval;   // evaluate the current key and write it back
        logic flush;  // hand out the held event as the final one
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic scan_ok;
        logic eval_ok;
        logic last_key;
        logic flush_ok;
    } t_status;

    localparam logic [7:0] CODE_TABLE [0:TBL_DIM-1][0:TBL_DIM-1] = '{
        '{8'h53, 8'h54, 8'h55, 8'h56, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h59, 8'h5A, 8'h5B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h5C, 8'h5D, 8'h5E, 8'h57, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h5F, 8'h60, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h62, 8'h63, 8'h58, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

endpackage

FILE: rtl/mkdr_ctrl.sv
// Sequencer of the key walk: accept, interval check, read/evaluate per key, flush.
// Depends on mkdr_pkg.
`timescale 1ns / 1ps

module mkdr_ctrl
    import mkdr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_CHECK;
            S_CHECK: n_state = i_status.scan_ok ? S_READ : S_IDLE;
            S_READ:  n_state = S_EVAL;
            S_EVAL: begin
                if (i_status.eval_ok) begin
                    n_state = i_status.last_key ? S_FLUSH : S_READ;
                end
            end
            S_FLUSH: if (i_status.flush_ok) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_CHECK: o_cmd.start = i_status.scan_ok;
            S_READ:  o_cmd.rd    = 1'b1;
            S_EVAL:  o_cmd.eval  = 1'b1;
            S_FLUSH: o_cmd.flush = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: rtl/mkdr_datapath.sv
// Key state memory, per-key phase logic, event holding stage and output register.
// Depends on mkdr_pkg; driven by mkdr_ctrl.
`timescale 1ns / 1ps

module mkdr_datapath
    import mkdr_pkg::*;
#(
    parameter int ROWS = 5,
    parameter int COLS = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    input  t_in_beat  i_in_data,
    input  logic      i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    localparam int NK = ROWS * COLS;
    localparam int IW = (NK > 1) ? $clog2(NK) : 1;
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;

    // Configuration.
    logic [15:0] r_scan_interval;
    logic [15:0] r_debounce_time;
    logic [15:0] r_long_press_time;
    logic [15:0] r_repeat_interval;
    logic [4:0]  r_max_events;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_interval   <= 16'd10;
            r_debounce_time   <= 16'd20;
            r_long_press_time <= 16'd1000;
            r_repeat_interval <= 16'd100;
            r_max_events      <= 5'd20;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCAN_INTERVAL:   r_scan_interval   <= i_cfg_data;
                CFG_DEBOUNCE_TIME:   r_debounce_time   <= i_cfg_data;
                CFG_LONG_PRESS_TIME: r_long_press_time <= i_cfg_data;
                CFG_REPEAT_INTERVAL: r_repeat_interval <= i_cfg_data;
                CFG_MAX_EVENTS:      r_max_events      <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Sample, scan stamp and walk position.
    logic [31:0] r_now;
    logic [19:0] r_map;
    logic [31:0] r_last_scan;
    logic [IW-1:0] r_idx;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [4:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now <= i_in_data.now_ms;
            r_map <= i_in_data.pressed_map;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_scan <= '0;
        end else if (i_cmd.start) begin
            r_last_scan <= r_now;
        end
    end

    logic [31:0] w_since;
    assign w_since          = r_now - r_last_scan;
    assign o_status.scan_ok = w_since >= 32'(r_scan_interval);

    // Key state memory: phase and phase start time. Timer contents only
    // matter once the entry has been written, so only the phase has a
    // valid flag that reads as idle.
    logic [33:0]   r_mem [NK];
    logic [33:0]   r_rd_data;
    logic [NK-1:0] r_valid;
    logic          r_rd_valid;

    logic [7:0]  w_code;
    logic        w_down;
    logic [63:0] w_map_ext;
    t_phase      w_phase;
    logic [31:0] w_timer;
    logic [31:0] w_held;
    t_phase      n_phase;
    logic [31:0] n_timer;
    logic        w_hit;
    logic [1:0]  w_kind;
    logic [4:0]  w_cap;
    logic        w_emit;
    logic        w_out_busy;
    logic        w_advance;

    // Map bits beyond the twenty sampled ones read as released.
    assign w_map_ext = 64'(r_map);
    assign w_code    = CODE_TABLE[3'(r_row)][3'(r_col)];
    assign w_down    = w_map_ext[6'(r_idx)];
    assign w_phase   = r_rd_valid ? t_phase'(r_rd_data[33:32]) : PH_IDLE;
    assign w_timer   = r_rd_data[31:0];
    assign w_held    = r_now - w_timer;

    always_comb begin
        n_phase = w_phase;
        n_timer = w_timer;
        w_hit   = 1'b0;
        w_kind  = EV_PRESS;
        unique case (w_phase)
            PH_IDLE: begin
                if (w_down) begin
                    n_phase = PH_DEBOUNCE;
                    n_timer = r_now;
                end
            end
            PH_DEBOUNCE: begin
                if (!w_down) begin
                    n_phase = PH_IDLE;
                end else if (w_held >= 32'(r_debounce_time)) begin
                    n_phase = PH_PRESSED;
                    n_timer = r_now;
                    w_hit   = 1'b1;
                    w_kind  = EV_PRESS;
                end
            end
            PH_PRESSED: begin
                if (!w_down) begin
                    n_phase = PH_IDLE;
                    w_hit   = 1'b1;
                    w_kind  = EV_RELEASE;
                end else if (w_held >= 32'(r_long_press_time)) begin
                    n_phase = PH_LONG;
                    n_timer = r_now;
                    w_hit   = 1'b1;
                    w_kind  = EV_LONG;
                end
            end
            PH_LONG: begin
                if (!w_down) begin
                    n_phase = PH_IDLE;
                    w_hit   = 1'b1;
                    w_kind  = EV_RELEASE;
                end else if (w_held >= 32'(r_repeat_interval)) begin
                    n_timer = r_now;
                    w_hit   = 1'b1;
                    w_kind  = EV_REPEAT;
                end
            end
            default: n_phase = w_phase;
        endcase
    end

    // Events past the cap are dropped; the key still advances.
    assign w_cap  = (r_max_events < 5'(RESULT_CAP)) ? r_max_events : 5'(RESULT_CAP);
    assign w_emit = (w_code != 8'h00) && w_hit && (r_count < w_cap);

    // The newest event is held back one step so that the final one of the
    // sample can be marked when the walk ends.
    logic      r_pend_v;
    t_out_beat r_pend;
    logic      r_out_valid;
    t_out_beat r_out;

    assign w_out_busy       = r_out_valid && i_out_stall;
    assign o_status.eval_ok = !(w_emit && r_pend_v && w_out_busy);
    assign o_status.last_key = r_idx == IW'(NK - 1);
    assign o_status.flush_ok = !(r_pend_v && w_out_busy);
    assign w_advance        = i_cmd.eval && o_status.eval_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_idx];
        end
        if (w_advance && (w_code != 8'h00)) begin
            r_mem[r_idx] <= {n_phase, n_timer};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_cmd.rd) begin
                r_rd_valid <= r_valid[r_idx];
            end
            if (w_advance && (w_code != 8'h00)) begin
                r_valid[r_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_count <= '0;
        end else if (i_cmd.start) begin
            r_idx   <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_count <= '0;
        end else if (w_advance) begin
            if (!o_status.last_key) begin
                r_idx <= r_idx + 1'b1;
                if (r_col == CW'(COLS - 1)) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (w_emit) begin
                r_count <= r_count + 5'd1;
            end
        end
    end

    logic w_push_out;
    logic w_last_out;
    assign w_push_out = r_pend_v && ((w_advance && w_emit) || (i_cmd.flush && !w_out_busy));
    assign w_last_out = i_cmd.flush;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance && w_emit) begin
                r_pend_v <= 1'b1;
            end else if (i_cmd.flush && !w_out_busy) begin
                r_pend_v <= 1'b0;
            end
            if (w_push_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_pend.key_id     <= w_code;
            r_pend.event_kind <= w_kind;
            r_pend.last_event <= 1'b0;
        end
        if (w_push_out) begin
            r_out.key_id     <= r_pend.key_id;
            r_out.event_kind <= r_pend.event_kind;
            r_out.last_event <= w_last_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 5'(RESULT_CAP))
        else $error("event count above the result cap");

    a_pend_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_count != 5'd0))
        else $error("held event without a counted emission");

    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push_out && w_last_out) |=> !r_pend_v && r_out_valid && r_out.last_event)
        else $error("final beat left an event behind");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !w_push_out)
        else $error("output register overwritten while stalled");

endmodule

FILE: rtl/matrix_key_debounce_repeat.sv
// Top level of the matrix key debounce, long press and auto-repeat block.
// Depends on mkdr_pkg, mkdr_ctrl and mkdr_datapath.
`timescale 1ns / 1ps

// Takes one timestamped sample of the key matrix per input beat and returns
// press, long-press, repeat and release events, the final one of a sample
// marked by last_event. A sample closer than scan_interval to the last
// accepted one is dropped at the interval check and yields nothing. An
// accepted sample walks all ROWS*COLS keys through the single-port state
// memory, each key as a registered read, then evaluate and write back,
// after accept and interval check and before the flush; the walk and flush
// stall only while the output stalls. Input is taken again once the walk
// ends, even while the final event still waits in the output register.
// No clearing pass is needed after reset.

module matrix_key_debounce_repeat
    import mkdr_pkg::*;
#(
    parameter int ROWS = 5,
    parameter int COLS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_beat    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_beat   o_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    mkdr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    mkdr_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: tb/tb_matrix_key_debounce_repeat.sv
`timescale 1ns / 1ps
// Self-checking testbench of matrix_key_debounce_repeat: timestamped key matrix samples go in,
// and every event beat that comes out is compared with a key-state predictor kept in the bench.
// Depends on mkdr_pkg and the RTL of the block.

module tb_matrix_key_debounce_repeat;
    import mkdr_pkg::*;

    localparam int ROWS = 5;
    localparam int COLS = 4;
    localparam int NKEYS = ROWS * COLS;
    localparam int SETTLE_CYCLES = 150;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS = 70;
    localparam logic [2:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CFG_SPARE_LAST = 3'd7;
    localparam logic [19:0] ALL_KEYS = 20'hFFFFF;
    localparam logic [19:0] NO_KEYS = 20'h00000;
    localparam logic [15:0] CFG_MAX = 16'hFFFF;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic o_in_stall;
    t_in_beat in_data = '0;
    logic o_out_valid;
    logic out_stall = 1'b0;
    t_out_beat o_out_data;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_idx = '0;
    logic [15:0] cfg_data = '0;

    // Predictor state: configuration, per-key phase and phase start time.
    logic [15:0] scan_gap;
    logic [15:0] debounce_ms;
    logic [15:0] long_ms;
    logic [15:0] repeat_ms;
    logic [4:0] event_cap;
    t_phase key_phase [NKEYS];
    logic [31:0] key_start [NKEYS];
    logic [31:0] last_scan;

    t_in_beat pending_samples [$];
    t_out_beat exp_events [$];
    t_out_beat want;

    int n_queued = 0;
    int n_sent = 0;
    int n_taken = 0;
    int n_checked = 0;
    int n_fail = 0;
    int scans_taken = 0;
    int writes_done = 0;
    int settings_run = 0;
    int gap_left = 0;
    int stall_left = 0;
    bit drain_hold = 1'b0;
    bit no_idle = 1'b0;

    logic [31:0] stamp;
    logic [19:0] held_keys;

    matrix_key_debounce_repeat #(.ROWS(ROWS), .COLS(COLS)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data(in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_data(o_out_data),
        .i_cfg_we(cfg_we),
        .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("[matrix_key_debounce_repeat] ERROR");
        $finish;
    end

    task automatic reset_model();
        scan_gap = 16'd10;
        debounce_ms = 16'd20;
        long_ms = 16'd1000;
        repeat_ms = 16'd100;
        event_cap = 5'd20;
        for (int k = 0; k < NKEYS; k++) begin
            key_phase[k] = PH_IDLE;
            key_start[k] = '0;
        end
        last_scan = '0;
    endtask

    // Walks the keys in row-major order and queues the events of one accepted scan.
    task automatic predict_scan(input t_in_beat s);
        t_out_beat ev [$];
        int cap;
        int k;
        logic [7:0] code;
        logic [31:0] since;
        logic [31:0] held;
        logic down;
        logic fire;
        logic [1:0] kind;
        cap = (event_cap < RESULT_CAP) ? event_cap : RESULT_CAP;
        since = s.now_ms - last_scan;
        if (since < {16'h0000, scan_gap}) return;
        scans_taken++;
        last_scan = s.now_ms;
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                k = r * COLS + c;
                code = CODE_TABLE[r][c];
                if (code != 8'h00) begin
                    down = s.pressed_map[k];
                    held = s.now_ms - key_start[k];
                    fire = 1'b0;
                    kind = EV_PRESS;
                    case (key_phase[k])
                        PH_IDLE: begin
                            if (down) begin
                                key_phase[k] = PH_DEBOUNCE;
                                key_start[k] = s.now_ms;
                            end
                        end
                        PH_DEBOUNCE: begin
                            if (!down) begin
                                key_phase[k] = PH_IDLE;
                            end else if (held >= debounce_ms) begin
                                key_phase[k] = PH_PRESSED;
                                key_start[k] = s.now_ms;
                                fire = 1'b1;
                                kind = EV_PRESS;
                            end
                        end
                        PH_PRESSED: begin
                            if (!down) begin
                                key_phase[k] = PH_IDLE;
                                fire = 1'b1;
                                kind = EV_RELEASE;
                            end else if (held >= long_ms) begin
                                key_phase[k] = PH_LONG;
                                key_start[k] = s.now_ms;
                                fire = 1'b1;
                                kind = EV_LONG;
                            end
                        end
                        default: begin
                            if (!down) begin
                                key_phase[k] = PH_IDLE;
                                fire = 1'b1;
                                kind = EV_RELEASE;
                            end else if (held >= repeat_ms) begin
                                key_start[k] = s.now_ms;
                                fire = 1'b1;
                                kind = EV_REPEAT;
                            end
                        end
                    endcase
                    // Over the cap the event is dropped but the key has already moved on.
                    if (fire && ev.size() < cap)
                        ev.push_back('{key_id: code, event_kind: kind, last_event: 1'b0});
                end
            end
        end
        if (ev.size() > 0) ev[ev.size() - 1].last_event = 1'b1;
        foreach (ev[i]) exp_events.push_back(ev[i]);
    endtask

    task automatic note_fail(input string msg);
        n_fail++;
        if (n_fail <= 10) $display("mismatch %0d: %s", n_fail, msg);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SCAN_INTERVAL: scan_gap = val;
            CFG_DEBOUNCE_TIME: debounce_ms = val;
            CFG_LONG_PRESS_TIME: long_ms = val;
            CFG_REPEAT_INTERVAL: repeat_ms = val;
            CFG_MAX_EVENTS: event_cap = val[4:0];
            default: ;
        endcase
        writes_done++;
    endtask

    task automatic set_regs(input logic [15:0] scan, input logic [15:0] deb,
                            input logic [15:0] lng, input logic [15:0] rep,
                            input logic [15:0] cap);
        write_reg(CFG_SCAN_INTERVAL, scan);
        write_reg(CFG_DEBOUNCE_TIME, deb);
        write_reg(CFG_LONG_PRESS_TIME, lng);
        write_reg(CFG_REPEAT_INTERVAL, rep);
        write_reg(CFG_MAX_EVENTS, cap);
        settings_run++;
    endtask

    task automatic push_sample(input logic [31:0] now, input logic [19:0] map);
        pending_samples.push_back('{now_ms: now, pressed_map: map});
        n_queued++;
    endtask

    // Waits until every sample is taken and every event has come, then lets the
    // walk of a sample without events finish before the registers change.
    task automatic drain();
        while (pending_samples.size() != 0 || n_taken != n_queued || exp_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly keys that are held and let go over well-spaced scans, with early
    // samples and random maps at random times mixed in.
    task automatic gen_random(input int count);
        int sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 8 && scan_gap != 16'h0000) begin
                push_sample(stamp + $urandom_range(0, scan_gap - 1), 20'($urandom));
            end else if (sel < 14) begin
                if ($urandom_range(0, 5) == 0)
                    stamp = stamp + $urandom;
                else
                    stamp = stamp + scan_gap + $urandom_range(0, 40);
                push_sample(stamp, 20'($urandom));
            end else begin
                for (int b = 0; b < NKEYS; b++)
                    if ($urandom_range(0, 11) == 0) held_keys[b] = ~held_keys[b];
                stamp = stamp + scan_gap + $urandom_range(0, 8);
                push_sample(stamp, held_keys);
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!in_valid || n_taken == n_sent) begin
                if (drain_hold && exp_events.size() == 0 && n_taken == n_sent)
                    drain_hold = 1'b0;
                if (gap_left > 0) begin
                    in_valid <= 1'b0;
                    gap_left--;
                end else if (!drain_hold && pending_samples.size() != 0) begin
                    in_data <= pending_samples.pop_front();
                    in_valid <= 1'b1;
                    n_sent++;
                    if (!no_idle && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 9);
                    if (!no_idle && $urandom_range(0, 39) == 0) drain_hold = 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            if (no_idle) begin
                out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else if ($urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(1, 9) - 1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Events are checked before the input beat of the same edge is predicted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !out_stall) begin
                n_checked++;
                if (exp_events.size() == 0) begin
                    note_fail($sformatf("unexpected event code %h kind %0d last %b",
                        o_out_data.key_id, o_out_data.event_kind, o_out_data.last_event));
                end else begin
                    want = exp_events.pop_front();
                    if (o_out_data.key_id !== want.key_id
                            || o_out_data.event_kind !== want.event_kind
                            || o_out_data.last_event !== want.last_event)
                        note_fail($sformatf(
                            "expected code %h kind %0d last %b, got code %h kind %0d last %b",
                            want.key_id, want.event_kind, want.last_event,
                            o_out_data.key_id, o_out_data.event_kind, o_out_data.last_event));
                end
            end
            if (in_valid && !o_in_stall) begin
                predict_scan(in_data);
                n_taken++;
            end
        end
    end

    initial begin
        reset_model();
        held_keys = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: early samples, debounce, press, long press, repeat, release,
        // a bounce back to idle, and map bits of keys that have no code.
        push_sample(32'd0, ALL_KEYS);
        push_sample(32'd9, ALL_KEYS);
        push_sample(32'd10, ALL_KEYS);
        push_sample(32'd29, ALL_KEYS);
        push_sample(32'd40, ALL_KEYS);
        push_sample(32'd1039, ALL_KEYS);
        push_sample(32'd1050, ALL_KEYS);
        push_sample(32'd1150, ALL_KEYS);
        push_sample(32'd1160, NO_KEYS);
        push_sample(32'd1170, 20'h00001);
        push_sample(32'd1180, NO_KEYS);
        push_sample(32'd1190, 20'h80088);
        push_sample(32'd1220, 20'h80088);
        push_sample(32'd1230, NO_KEYS);
        drain();

        // All times zero and a small cap: every scan is taken even at the same stamp.
        set_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd5);
        for (int n = 0; n < 4; n++) push_sample(32'd2000, ALL_KEYS);
        push_sample(32'd2000, NO_KEYS);
        drain();

        // A cap of zero drops every event while the keys still advance.
        write_reg(CFG_MAX_EVENTS, 16'd0);
        for (logic [3:0] idx = CFG_SPARE_FIRST; idx <= CFG_SPARE_LAST; idx++)
            write_reg(idx[2:0], 16'($urandom));
        push_sample(32'd2001, ALL_KEYS);
        push_sample(32'd2002, ALL_KEYS);
        push_sample(32'd2003, ALL_KEYS);
        drain();
        write_reg(CFG_MAX_EVENTS, 16'd20);
        push_sample(32'd2004, ALL_KEYS);
        push_sample(32'd2005, NO_KEYS);
        drain();

        // Largest intervals, with steps one short of them and exactly on them.
        set_regs(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, 16'd20);
        stamp = 32'd2005;
        push_sample(stamp + CFG_MAX - 1, ALL_KEYS);
        for (int n = 0; n < 4; n++) begin
            stamp = stamp + CFG_MAX;
            push_sample(stamp, ALL_KEYS);
        end
        stamp = stamp + CFG_MAX;
        push_sample(stamp, NO_KEYS);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == RANDOM_PHASES - 1) no_idle = 1'b1;
            set_regs(16'($urandom_range(0, 6)), 16'($urandom_range(0, 12)),
                     16'($urandom_range(0, 60)), 16'($urandom_range(0, 20)),
                     16'((p == 1) ? $urandom_range(1, 6) : $urandom_range(10, 20)));
            // One phase runs the timestamp across its wrap.
            if (p == 2) stamp = 32'hFFFF_FF80;
            gen_random(PHASE_ITEMS);
            drain();
        end

        $display("Run covered %0d samples, %0d accepted scans and %0d checked events,",
                 n_queued, scans_taken, n_checked);
        $display("over %0d register settings (%0d writes); %0d mismatches.",
                 settings_run, writes_done, n_fail);
        if (n_fail == 0)
            $display("[matrix_key_debounce_repeat] OK");
        else
            $display("[matrix_key_debounce_repeat] ERROR");
        $finish;
    end

endmodule

FILE: matrix_key_debounce_repeat.f
rtl/mkdr_pkg.sv
rtl/mkdr_ctrl.sv
rtl/mkdr_datapath.sv
rtl/matrix_key_debounce_repeat.sv
tb/tb_matrix_key_debounce_repeat.sv
